// ===== sv/pts_pkg.sv =====
// Shared types and codes for the periodic timer scheduler.
// Used by periodic_timer_scheduler_top; depends on nothing else.
`default_nettype none

package pts_pkg;

  // Default sizes of the timer table.
  localparam int unsigned TIMER_SLOTS_DEF = 16;
  localparam int unsigned HANDLE_BITS_DEF = 16;

  // Request codes.
  localparam logic [1:0] REQ_CREATE  = 2'd0;
  localparam logic [1:0] REQ_DESTROY = 2'd1;
  localparam logic [1:0] REQ_REMOVE  = 2'd2;
  localparam logic [1:0] REQ_POLL    = 2'd3;

  // Response status codes.
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_IGNORED = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_FIRED   = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;
  localparam logic [2:0] ST_WAITING = 3'd5;

  // One request transaction.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] owner_handle;
    logic [31:0] timer_id;
    logic [31:0] period;
    logic [31:0] callback_tag;
    logic [31:0] now_tick;
  } req_t;

  // One response transaction.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] fired_handle;
    logic [31:0] fired_id;
    logic [31:0] fired_tag;
    logic [31:0] fired_period;
    logic [31:0] ticks_left;
  } rsp_t;

endpackage

`default_nettype wire

// ===== sv/periodic_timer_scheduler_top.sv =====
// Periodic timer scheduler: a table of periodic timers with create, destroy,
// remove-by-handle and poll requests. Depends on pts_pkg.
// A request is captured, the scan reads the timer memory one slot per cycle into the
// compare stage, and the update step then loads the response register once it is free;
// a create with period zero skips the scan. A new request is taken only after the
// update step, once the block is back in idle.
// Reset clears the slot valid bits and the order counter at once; the timer memory
// itself is not cleared, and a new request may be accepted while a response waits.
`default_nettype none

module periodic_timer_scheduler_top #(
  parameter int unsigned TIMER_SLOTS = pts_pkg::TIMER_SLOTS_DEF,
  parameter int unsigned HANDLE_BITS = pts_pkg::HANDLE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire pts_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output pts_pkg::rsp_t      rsp
);
  import pts_pkg::*;

  localparam int unsigned AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  // One stored timer.
  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [31:0]            id;
    logic [31:0]            period;
    logic [31:0]            tag;
    logic [31:0]            due;
    logic [31:0]            order;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t                 state;
  req_t                   req_q;
  logic [TIMER_SLOTS-1:0] slot_valid;
  logic [31:0]            order_counter;

  // Scan pipeline: read address issue, and the compare stage in the cycle after.
  logic [AW-1:0] rd_addr;
  logic          issue_done;
  logic          issuing;
  logic          cmp_vld;
  logic [AW-1:0] cmp_idx;
  entry_t        rd_data;

  // Scan results.
  logic          match_found;
  logic [AW-1:0] match_idx;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic          best_found;
  logic [AW-1:0] best_idx;
  entry_t        best_entry;
  logic [31:0]   best_age;

  // Timer memory.
  entry_t mem [TIMER_SLOTS];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  logic [63:0]            req_handle_wide;
  logic [HANDLE_BITS-1:0] key_handle;
  logic [63:0]            best_handle_wide;
  logic                   cmp_slot_valid;
  logic                   handle_hit;
  logic                   key_hit;
  logic [31:0]            cand_age;
  logic                   take_best;
  logic                   out_free;
  logic                   commit;
  logic                   period_zero;

  // Update-step arithmetic.
  logic [31:0] due_base;
  logic [31:0] due_sum;
  logic [31:0] left;
  logic        is_due;

  // Update-step decisions.
  rsp_t          rsp_next;
  logic          valid_set;
  logic          valid_clr;
  logic [AW-1:0] valid_idx;
  logic          order_inc;

  // Key formed the same way it is stored.
  assign req_handle_wide = {48'd0, req_q.owner_handle};
  assign key_handle      = req_handle_wide[HANDLE_BITS-1:0];
  assign best_handle_wide = 64'(best_entry.handle);

  assign req_ready   = (state == S_IDLE);
  assign issuing     = (state == S_SCAN) && !issue_done;
  assign out_free    = !rsp_valid || rsp_ready;
  assign commit      = (state == S_WRITE) && out_free;
  assign period_zero = (req_q.req_type == REQ_CREATE) && (req_q.period == 32'd0);

  // Compare stage: one slot per cycle.
  assign cmp_slot_valid = slot_valid[cmp_idx];
  assign handle_hit     = cmp_slot_valid && (rd_data.handle == key_handle);
  assign key_hit        = handle_hit && (rd_data.id == req_q.timer_id);
  assign cand_age       = order_counter - rd_data.order;
  assign take_best      = cmp_slot_valid &&
                          (!best_found || (rd_data.due < best_entry.due) ||
                           ((rd_data.due == best_entry.due) && (cand_age > best_age)));

  // Poll arithmetic on the chosen timer.
  assign due_base = (best_entry.due == 32'd0) ? req_q.now_tick : best_entry.due;
  assign due_sum  = due_base + best_entry.period;
  assign left     = best_entry.due - req_q.now_tick;
  assign is_due   = (best_entry.due <= req_q.now_tick);

  // Update step: response, memory write and valid bit change.
  always_comb begin
    rsp_next  = '0;
    wr_en     = 1'b0;
    wr_addr   = best_idx;
    wr_data   = best_entry;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    valid_idx = match_idx;
    order_inc = 1'b0;
    rsp_next.status = ST_DONE;
    unique case (req_q.req_type)
      REQ_CREATE: begin
        if (period_zero) begin
          rsp_next.status = ST_IGNORED;
        end else if (!match_found && !free_found) begin
          rsp_next.status = ST_FULL;
        end else begin
          wr_en          = commit;
          wr_addr        = match_found ? match_idx : free_idx;
          wr_data.handle = key_handle;
          wr_data.id     = req_q.timer_id;
          wr_data.period = req_q.period;
          wr_data.tag    = req_q.callback_tag;
          wr_data.due    = 32'd0;
          wr_data.order  = order_counter;
          valid_set      = commit;
          valid_idx      = wr_addr;
          order_inc      = commit;
        end
      end
      REQ_DESTROY: begin
        valid_clr = commit && match_found;
      end
      REQ_REMOVE: begin
        rsp_next.status = ST_DONE;
      end
      REQ_POLL: begin
        if (!best_found) begin
          rsp_next.status = ST_EMPTY;
        end else if (is_due) begin
          rsp_next.status       = ST_FIRED;
          rsp_next.fired_handle = best_handle_wide[15:0];
          rsp_next.fired_id     = best_entry.id;
          rsp_next.fired_tag    = best_entry.tag;
          rsp_next.fired_period = best_entry.period;
          wr_en                 = commit;
          wr_data.due           = due_sum;
          wr_data.order         = order_counter;
          order_inc             = commit;
        end else begin
          rsp_next.status     = ST_WAITING;
          rsp_next.ticks_left = left;
        end
      end
      default: begin
        rsp_next.status = ST_DONE;
      end
    endcase
  end

  // Timer memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer and scan control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issue_done <= 1'b0;
      cmp_vld    <= 1'b0;
      rd_addr    <= '0;
    end else begin
      cmp_vld <= issuing;
      cmp_idx <= rd_addr;
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            rd_addr    <= '0;
            issue_done <= 1'b0;
            if ((req.req_type == REQ_CREATE) && (req.period == 32'd0)) begin
              state <= S_WRITE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issuing) begin
            rd_addr <= rd_addr + AW'(1);
            if (rd_addr == AW'(TIMER_SLOTS - 1)) begin
              issue_done <= 1'b1;
            end
          end
          if (cmp_vld && (cmp_idx == AW'(TIMER_SLOTS - 1))) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request capture and scan results.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q       <= req;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      best_found  <= 1'b0;
    end else if (cmp_vld) begin
      if (key_hit && !match_found) begin
        match_found <= 1'b1;
        match_idx   <= cmp_idx;
      end
      if (!cmp_slot_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
      if (take_best) begin
        best_found <= 1'b1;
        best_idx   <= cmp_idx;
        best_entry <= rd_data;
        best_age   <= cand_age;
      end
    end
  end

  // Valid bits and insertion order counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= '0;
      order_counter <= '0;
    end else begin
      if (cmp_vld && (req_q.req_type == REQ_REMOVE) && handle_hit) begin
        slot_valid[cmp_idx] <= 1'b0;
      end
      if (valid_set) begin
        slot_valid[valid_idx] <= 1'b1;
      end else if (valid_clr) begin
        slot_valid[valid_idx] <= 1'b0;
      end
      if (order_inc) begin
        order_counter <= order_counter + 32'd1;
      end
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp <= rsp_next;
    end
  end

  // A new response appears only from the update step.
  a_rsp_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_WRITE))
    else $error("response raised outside the update step");

  // A fired timer always carries a nonzero period.
  a_fired_period: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == ST_FIRED)) |-> (rsp.fired_period != 32'd0))
    else $error("fired timer with zero period");

  // Compare stage is active only while scanning.
  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_vld |-> (state == S_SCAN))
    else $error("compare stage active outside scan");

  // Table full is reported only when every slot is in use.
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    (commit && (req_q.req_type == REQ_CREATE) && !period_zero &&
     !match_found && !free_found) |-> (&slot_valid))
    else $error("table full reported with a free slot");

endmodule

`default_nettype wire
